// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/dbd_pkg.sv =====
// ---------------------------------------------------------------------------
// Dictionary block deframer package
// Types and constants shared by the deframer modules.
// ---------------------------------------------------------------------------
package dbd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ENDED   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    FLD_NONE    = 3'd0,
    FLD_HW_LEN  = 3'd1,
    FLD_HW      = 3'd2,
    FLD_DEF_LEN = 3'd3,
    FLD_DEF     = 3'd4,
    FLD_ALT_LEN = 3'd5,
    FLD_ALT     = 3'd6
  } field_t;

  localparam logic [3:0] TYPE_ENTRY     = 4'd1;
  localparam logic [3:0] TYPE_END       = 4'd4;
  localparam logic [3:0] TYPE_ENTRY_ALT = 4'd10;
  localparam logic [3:0] CODE_DIRECT    = 4'd4;
  localparam logic [7:0] CTRL_LIMIT     = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;

  typedef struct packed {
    logic start;
    logic step;
    logic is_entry;
  } entry_ctrl_t;

  typedef struct packed {
    logic [2:0] tag;
    logic       kept;
  } entry_info_t;

  typedef struct packed {
    logic [3:0]  block_type;
    logic [7:0]  payload_byte;
    logic [31:0] byte_offset;
    logic [2:0]  field_tag;
    logic        byte_kept;
    logic        block_last;
    logic        block_empty;
    logic        end_marker;
  } result_t;

endpackage

// ===== rtl/dbd_if.sv =====
// ---------------------------------------------------------------------------
// Deframer stream interfaces
// Valid/ready channels for incoming stream bytes and outgoing result words.
// ---------------------------------------------------------------------------
interface dbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface dbd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  block_type;
  logic [7:0]  payload_byte;
  logic [31:0] byte_offset;
  logic [2:0]  field_tag;
  logic        byte_kept;
  logic        block_last;
  logic        block_empty;
  logic        end_marker;

  modport source (
    output valid, output block_type, output payload_byte, output byte_offset,
    output field_tag, output byte_kept, output block_last, output block_empty,
    output end_marker, input ready
  );
  modport sink (
    input valid, input block_type, input payload_byte, input byte_offset,
    input field_tag, input byte_kept, input block_last, input block_empty,
    input end_marker, output ready
  );
endinterface

// ===== rtl/dbd_entry_tracker.sv =====
// ---------------------------------------------------------------------------
// Entry field tracker
// Follows the field layout of entry blocks and tags each payload byte.
// ---------------------------------------------------------------------------
module dbd_entry_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  dbd_pkg::entry_ctrl_t ctrl,
  input  logic [7:0]          data_byte,
  output dbd_pkg::entry_info_t info
);
  import dbd_pkg::*;

  field_t      field_r, field_nxt;
  logic [15:0] left_r, left_nxt;
  logic        cut_r, cut_nxt;
  logic        hi_done_r, hi_done_nxt;
  logic [15:0] left_dec;
  logic [15:0] def_len;
  logic        ctrl_byte;

  assign left_dec  = left_r - 16'd1;
  assign def_len   = left_r | {8'd0, data_byte};
  assign ctrl_byte = (data_byte < CTRL_LIMIT) && (data_byte != CHAR_NEWLINE);

  always_comb begin
    field_nxt   = field_r;
    left_nxt    = left_r;
    cut_nxt     = cut_r;
    hi_done_nxt = hi_done_r;
    info.tag    = 3'(field_r);
    info.kept   = 1'b1;
    unique case (field_r)
      FLD_NONE: begin
      end
      FLD_HW_LEN: begin
        left_nxt = {8'd0, data_byte};
        if (data_byte != 8'd0) begin
          field_nxt = FLD_HW;
        end else begin
          field_nxt   = FLD_DEF_LEN;
          hi_done_nxt = 1'b0;
        end
      end
      FLD_HW: begin
        left_nxt = left_dec;
        if (left_dec == 16'd0) begin
          field_nxt   = FLD_DEF_LEN;
          hi_done_nxt = 1'b0;
        end
      end
      FLD_DEF_LEN: begin
        if (!hi_done_r) begin
          left_nxt    = {data_byte, 8'd0};
          hi_done_nxt = 1'b1;
        end else begin
          left_nxt  = def_len;
          cut_nxt   = 1'b0;
          field_nxt = (def_len != 16'd0) ? FLD_DEF : FLD_ALT_LEN;
        end
      end
      FLD_DEF: begin
        // Once a control byte shows up, the rest of the definition is dropped.
        cut_nxt   = cut_r | ctrl_byte;
        info.kept = !(cut_r | ctrl_byte);
        left_nxt  = left_dec;
        if (left_dec == 16'd0) begin
          field_nxt = FLD_ALT_LEN;
        end
      end
      FLD_ALT_LEN: begin
        left_nxt = {8'd0, data_byte};
        if (data_byte != 8'd0) begin
          field_nxt = FLD_ALT;
        end
      end
      FLD_ALT: begin
        left_nxt = left_dec;
        if (left_dec == 16'd0) begin
          field_nxt = FLD_ALT_LEN;
        end
      end
      default: begin
        info.tag = 3'(FLD_NONE);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r   <= FLD_NONE;
      left_r    <= '0;
      cut_r     <= 1'b0;
      hi_done_r <= 1'b0;
    end else if (ctrl.start) begin
      field_r   <= ctrl.is_entry ? FLD_HW_LEN : FLD_NONE;
      left_r    <= '0;
      cut_r     <= 1'b0;
      hi_done_r <= 1'b0;
    end else if (ctrl.step) begin
      field_r   <= field_nxt;
      left_r    <= left_nxt;
      cut_r     <= cut_nxt;
      hi_done_r <= hi_done_nxt;
    end
  end

endmodule

// ===== rtl/dictionary_block_deframer_top.sv =====
// Output: the result word for an accepted byte is registered in the output register.
// Throughput: one byte per cycle; the single output register passes ready straight back,
// so a byte is taken whenever the register is empty or being emptied in the same cycle.
// Reset: synchronous, active low; clears the parse state and the output valid, no sweep.
// ---------------------------------------------------------------------------
// Dictionary block deframer
// Splits the decompressed byte stream into blocks and emits one word per
// payload byte, one per empty block and one for the end marker.
// ---------------------------------------------------------------------------
module dictionary_block_deframer_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  dbd_in_if.sink          in_ch,
  dbd_out_if.source       out_ch
);
  import dbd_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             type_r, type_nxt;
  logic [2:0]             len_left_r, len_left_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  result_t                out_res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_ready;
  logic                   in_fire;
  logic [7:0]             b;
  logic [3:0]             code;
  logic [LENGTH_BITS-1:0] rem_shift;
  logic [2:0]             len_dec;
  logic                   last_byte;
  logic                   start_pl;
  entry_ctrl_t            ent_ctrl;
  entry_info_t            ent_info;

  assign b         = in_ch.data_byte;
  assign code      = b[7:4];
  assign in_ready  = !out_valid_r || out_ch.ready;
  assign in_fire   = in_ch.valid && in_ready;
  assign rem_shift = LENGTH_BITS'({rem_r, b});
  assign len_dec   = len_left_r - 3'd1;
  assign last_byte = (rem_r == LENGTH_BITS'(1));

  // Next state.
  always_comb begin
    phase_nxt    = phase_r;
    type_nxt     = type_r;
    len_left_nxt = len_left_r;
    rem_nxt      = rem_r;
    pos_nxt      = pos_r;
    start_pl     = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          type_nxt = b[3:0];
          if (b[3:0] == TYPE_END) begin
            phase_nxt = PH_ENDED;
          end else if (code < CODE_DIRECT) begin
            len_left_nxt = {1'b0, code[1:0]} + 3'd1;
            rem_nxt      = '0;
            phase_nxt    = PH_LENGTH;
          end else begin
            rem_nxt = LENGTH_BITS'(code - CODE_DIRECT);
            if (code != CODE_DIRECT) begin
              start_pl  = 1'b1;
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_LENGTH: begin
          rem_nxt      = rem_shift;
          len_left_nxt = len_dec;
          if (len_dec == 3'd0) begin
            if (rem_shift == '0) begin
              phase_nxt = PH_HEADER;
            end else begin
              start_pl  = 1'b1;
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          pos_nxt = pos_r + LENGTH_BITS'(1);
          rem_nxt = rem_r - LENGTH_BITS'(1);
          if (last_byte) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_ENDED: begin
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
      if (start_pl) begin
        pos_nxt = '0;
      end
    end
  end

  assign ent_ctrl.start    = start_pl;
  assign ent_ctrl.step     = in_fire && (phase_r == PH_PAYLOAD);
  assign ent_ctrl.is_entry = (type_nxt == TYPE_ENTRY) || (type_nxt == TYPE_ENTRY_ALT);

  dbd_entry_tracker u_entry (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ent_ctrl),
    .data_byte (b),
    .info      (ent_info)
  );

  // Result word for the accepted byte.
  always_comb begin
    res_nxt           = '0;
    res_nxt.byte_kept = 1'b1;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    if (in_fire) begin
      out_valid_nxt = 1'b0;
      unique case (phase_r)
        PH_HEADER: begin
          res_nxt.block_type = b[3:0];
          if (b[3:0] == TYPE_END) begin
            res_nxt.end_marker = 1'b1;
            out_valid_nxt      = 1'b1;
          end else if (code == CODE_DIRECT) begin
            res_nxt.block_empty = 1'b1;
            out_valid_nxt       = 1'b1;
          end
        end
        PH_LENGTH: begin
          res_nxt.block_type = type_r;
          if ((len_dec == 3'd0) && (rem_shift == '0)) begin
            res_nxt.block_empty = 1'b1;
            out_valid_nxt       = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res_nxt.block_type   = type_r;
          res_nxt.payload_byte = b;
          res_nxt.byte_offset  = 32'(pos_r);
          res_nxt.field_tag    = ent_info.tag;
          res_nxt.byte_kept    = ent_info.kept;
          res_nxt.block_last   = last_byte;
          out_valid_nxt        = 1'b1;
        end
        PH_ENDED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      type_r      <= '0;
      len_left_r  <= '0;
      rem_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      type_r      <= type_nxt;
      len_left_r  <= len_left_nxt;
      rem_r       <= rem_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.block_type   = out_res_r.block_type;
  assign out_ch.payload_byte = out_res_r.payload_byte;
  assign out_ch.byte_offset  = out_res_r.byte_offset;
  assign out_ch.field_tag    = out_res_r.field_tag;
  assign out_ch.byte_kept    = out_res_r.byte_kept;
  assign out_ch.block_last   = out_res_r.block_last;
  assign out_ch.block_empty  = out_res_r.block_empty;
  assign out_ch.end_marker   = out_res_r.end_marker;

endmodule

// ===== rtl/dbd_checker.sv =====
// ---------------------------------------------------------------------------
// Deframer port checker
// Watches the top-level channels for handshake and end-of-stream behavior.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_block_type,
  input logic [7:0] out_payload_byte,
  input logic       out_end_marker
);
  import dbd_pkg::*;

  logic stalled;
  logic end_acc;
  logic in_acc;
  logic bad_end;

  assign stalled = out_valid && !out_ready;
  assign end_acc = out_valid && out_ready && out_end_marker;
  assign in_acc  = in_valid && in_ready;
  assign bad_end = out_end_marker &&
                   ((out_block_type != TYPE_END) || (out_payload_byte != 8'd0));

  // A stalled result word must stay offered.
  `ASSERT_CLK(a_out_hold, clk, rst_n, stalled |=> out_valid, "result word dropped while stalled")

  // With nothing in the output register the input side must be open.
  `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input blocked")

  // The end word carries type 4 and no payload.
  `ASSERT_NEVER(a_end_shape, clk, rst_n, out_valid && bad_end, "malformed end word")

  // Nothing follows the end word until reset.
  `ASSERT_CLK(a_silent_after_end, clk, rst_n, end_acc |=> !out_valid, "word after end marker")

  // Input bytes taken after the end word must not produce output.
  `ASSERT_CLK(a_no_late_words, clk, rst_n, $past(end_acc) && in_acc |=> !out_valid, "late word")

endmodule

bind dictionary_block_deframer_top dbd_checker u_dbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_block_type   (out_ch.block_type),
  .out_payload_byte (out_ch.payload_byte),
  .out_end_marker   (out_ch.end_marker)
);
